// ===== design/cfc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfc_pkg
// Types and constants shared by the command frame checker: the beat payloads
// of the byte and verdict channels, verdict codes and frame markers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfc_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } cfc_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic       reinit_request;
        logic       stream_on;
    } cfc_out_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED    = 3'd0,
        ST_SHORT       = 3'd1,
        ST_BAD_HEADER  = 3'd2,
        ST_BAD_LENGTH  = 3'd3,
        ST_BAD_FOOTER  = 3'd4,
        ST_BAD_CHECKSUM = 3'd5,
        ST_UNKNOWN_CMD = 3'd6
    } cfc_status_t;

    // Bit positions in the per-packet error flags.
    localparam int unsigned FLAG_HEADER   = 0;
    localparam int unsigned FLAG_CHECKSUM = 1;
    localparam int unsigned FLAG_FOOTER   = 2;
    localparam int unsigned FLAG_NEWLINE  = 3;

    localparam logic [8:0] POS_MAX        = 9'd511;
    localparam logic [9:0] FRAME_OVERHEAD = 10'd11;

    localparam logic [7:0] KIND_REINIT  = 8'hA1;
    localparam logic [7:0] KIND_STREAM  = 8'hA2;
    localparam logic [7:0] ARG_ON       = 8'h01;
    localparam logic [7:0] ARG_OFF      = 8'h02;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // "FUT0" and "END0".
    localparam logic [7:0] HEAD_MARK [4] = '{8'h46, 8'h55, 8'h54, 8'h30};
    localparam logic [7:0] TAIL_MARK [4] = '{8'h45, 8'h4E, 8'h44, 8'h30};

endpackage

// ===== design/command_frame_checker.sv =====
// ----------------------------------------------------------------------------
// command_frame_checker
// Checks a command packet one byte beat at a time and gives one verdict beat
// on the last byte.
// Throughput: one byte beat per cycle; in_ready drops only while a verdict
// is held in the output register and out_ready is low.
// Latency: the verdict is valid the cycle after the last byte is accepted.
// Reset clears all per-packet state and sets the stream enable flag to on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_frame_checker
    import cfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cfc_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output cfc_out_t out_data
);

    logic [8:0] pos_reg,    pos_next;
    logic [7:0] len_reg,    len_next;
    logic [7:0] xor_reg,    xor_next;
    logic [7:0] kind_reg,   kind_next;
    logic [7:0] first_reg,  first_next;
    logic [3:0] flags_reg,  flags_next;
    logic       stream_reg, stream_next;
    logic       out_valid_reg;
    cfc_out_t   out_data_reg;

    logic       accept;
    logic [7:0] b;
    logic [9:0] p10;
    logic [9:0] len10;
    logic [9:0] tail_off;
    logic [8:0] n;
    logic [9:0] n10;
    logic [9:0] lnext10;
    logic       len_ok;
    logic [2:0] status;
    logic       reinit;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign b        = in_data.rx_byte;
    assign p10      = {1'b0, pos_reg};
    assign len10    = {2'b00, len_reg};
    assign tail_off = p10 - 10'd7 - len10;
    assign n        = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 9'd1;

    // Per-byte update of the packet state.
    always_comb
    begin
        len_next   = len_reg;
        xor_next   = xor_reg;
        kind_next  = kind_reg;
        first_next = first_reg;
        flags_next = flags_reg;
        if (p10 < 10'd4)
        begin
            if (b != HEAD_MARK[pos_reg[1:0]])
                flags_next[FLAG_HEADER] = 1'b1;
        end
        else if (p10 == 10'd4)
        begin
            kind_next = b;
            xor_next  = xor_reg ^ b;
        end
        else if (p10 == 10'd5)
        begin
            len_next = b;
            xor_next = xor_reg ^ b;
        end
        else if (p10 < 10'd6 + len10)
        begin
            if (p10 == 10'd6)
                first_next = b;
            xor_next = xor_reg ^ b;
        end
        else if (p10 == 10'd6 + len10)
        begin
            if (b != xor_reg)
                flags_next[FLAG_CHECKSUM] = 1'b1;
        end
        else if (p10 < FRAME_OVERHEAD + len10)
        begin
            if (b != TAIL_MARK[tail_off[1:0]])
                flags_next[FLAG_FOOTER] = 1'b1;
        end
        else if (p10 == FRAME_OVERHEAD + len10)
        begin
            if (b != NEWLINE_BYTE)
                flags_next[FLAG_NEWLINE] = 1'b1;
        end
    end

    // Verdict, taken from the state as it stands after this byte.
    assign n10     = {1'b0, n};
    assign lnext10 = {2'b00, len_next};
    assign len_ok  = (n10 == lnext10 + FRAME_OVERHEAD) ||
                     ((n10 == lnext10 + FRAME_OVERHEAD + 10'd1) &&
                      !flags_next[FLAG_NEWLINE]);

    always_comb
    begin
        status      = ST_UNKNOWN_CMD;
        reinit      = 1'b0;
        stream_next = stream_reg;
        if (n10 < FRAME_OVERHEAD)
            status = ST_SHORT;
        else if (flags_next[FLAG_HEADER])
            status = ST_BAD_HEADER;
        else if (!len_ok)
            status = ST_BAD_LENGTH;
        else if (flags_next[FLAG_FOOTER])
            status = ST_BAD_FOOTER;
        else if (flags_next[FLAG_CHECKSUM])
            status = ST_BAD_CHECKSUM;
        else if (len_next != 8'd0)
        begin
            if (kind_next == KIND_REINIT && first_next == ARG_ON)
            begin
                status = ST_ACCEPTED;
                reinit = 1'b1;
            end
            else if (kind_next == KIND_STREAM && first_next == ARG_ON)
            begin
                status      = ST_ACCEPTED;
                stream_next = 1'b1;
            end
            else if (kind_next == KIND_STREAM && first_next == ARG_OFF)
            begin
                status      = ST_ACCEPTED;
                stream_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            len_reg       <= '0;
            xor_reg       <= '0;
            kind_reg      <= '0;
            first_reg     <= '0;
            flags_reg     <= '0;
            stream_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && in_data.last_byte)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                if (in_data.last_byte)
                begin
                    // The packet ends here: clear everything but the stream flag.
                    pos_reg       <= '0;
                    len_reg       <= '0;
                    xor_reg       <= '0;
                    kind_reg      <= '0;
                    first_reg     <= '0;
                    flags_reg     <= '0;
                    stream_reg    <= stream_next;
                end
                else
                begin
                    pos_reg   <= n;
                    len_reg   <= len_next;
                    xor_reg   <= xor_next;
                    kind_reg  <= kind_next;
                    first_reg <= first_next;
                    flags_reg <= flags_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.last_byte)
        begin
            out_data_reg.status         <= status;
            out_data_reg.reinit_request <= reinit;
            out_data_reg.stream_on      <= stream_next;
        end
    end

`ifndef SYNTH
    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.last_byte |=> out_valid_reg && pos_reg == 9'd0)
        else $error("last byte did not produce a verdict or clear the position");

    a_reinit_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.reinit_request |->
            out_data_reg.status == ST_ACCEPTED)
        else $error("reinit request on a rejected packet");

    a_stream_changes_on_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        stream_reg != $past(stream_reg) |-> $past(accept && in_data.last_byte))
        else $error("stream flag changed without a completed packet");

    a_verdict_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.last_byte |=> out_data_reg.stream_on == stream_reg)
        else $error("reported stream flag differs from kept flag");

    a_status_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.status <= ST_UNKNOWN_CMD)
        else $error("verdict code out of range");
`endif

endmodule

// ===== test/cfc_checker.sv =====
// ----------------------------------------------------------------------------
// cfc_checker
// Watches the byte and verdict channels of the command frame checker. It
// predicts one verdict for every byte beat that closes a packet and compares
// each verdict beat against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfc_checker
    import cfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  cfc_in_t     in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  cfc_out_t    out_data,
    output int unsigned mismatch_count,
    output int unsigned verdicts_owed
);

    cfc_out_t   verdict_q [$];

    // Predicted per-packet state and the kept stream flag.
    logic [8:0] pos;
    logic [7:0] len_byte;
    logic [7:0] xor_acc;
    logic [7:0] kind;
    logic [7:0] arg;
    logic [3:0] flags;
    logic       stream_en;

    task automatic clear_packet();
        pos      = '0;
        len_byte = '0;
        xor_acc  = '0;
        kind     = '0;
        arg      = '0;
        flags    = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int unsigned p;
        int unsigned n;
        int unsigned len;
        cfc_out_t    v;

        p   = pos;
        len = len_byte;
        if (p < 4)
        begin
            if (b != HEAD_MARK[p]) flags[FLAG_HEADER] = 1'b1;
        end
        else if (p == 4)
        begin
            kind    = b;
            xor_acc = xor_acc ^ b;
        end
        else if (p == 5)
        begin
            len_byte = b;
            xor_acc  = xor_acc ^ b;
        end
        else if (p < 6 + len)
        begin
            if (p == 6) arg = b;
            xor_acc = xor_acc ^ b;
        end
        else if (p == 6 + len)
        begin
            if (b != xor_acc) flags[FLAG_CHECKSUM] = 1'b1;
        end
        else if (p < 11 + len)
        begin
            if (b != TAIL_MARK[p - 7 - len]) flags[FLAG_FOOTER] = 1'b1;
        end
        else if (p == 11 + len)
        begin
            if (b != NEWLINE_BYTE) flags[FLAG_NEWLINE] = 1'b1;
        end
        n   = (p >= POS_MAX) ? POS_MAX : p + 1;
        pos = n[8:0];

        if (last)
        begin
            len              = len_byte;
            v.reinit_request = 1'b0;
            if (n < FRAME_OVERHEAD)
            begin
                v.status = ST_SHORT;
            end
            else if (flags[FLAG_HEADER])
            begin
                v.status = ST_BAD_HEADER;
            end
            else if (!((n == len + FRAME_OVERHEAD) ||
                       ((n == len + FRAME_OVERHEAD + 1) && !flags[FLAG_NEWLINE])))
            begin
                v.status = ST_BAD_LENGTH;
            end
            else if (flags[FLAG_FOOTER])
            begin
                v.status = ST_BAD_FOOTER;
            end
            else if (flags[FLAG_CHECKSUM])
            begin
                v.status = ST_BAD_CHECKSUM;
            end
            else
            begin
                v.status = ST_UNKNOWN_CMD;
                if (len >= 1)
                begin
                    if (kind == KIND_REINIT && arg == ARG_ON)
                    begin
                        v.reinit_request = 1'b1;
                        v.status         = ST_ACCEPTED;
                    end
                    else if (kind == KIND_STREAM && arg == ARG_ON)
                    begin
                        stream_en = 1'b1;
                        v.status  = ST_ACCEPTED;
                    end
                    else if (kind == KIND_STREAM && arg == ARG_OFF)
                    begin
                        stream_en = 1'b0;
                        v.status  = ST_ACCEPTED;
                    end
                end
            end
            v.stream_on = stream_en;
            verdict_q.push_back(v);
            clear_packet();
        end
    endtask

    task automatic flag_mismatch(input string why, input cfc_out_t want,
                                 input cfc_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: verdict %s: expected status %0d reinit %0b stream %0b,",
                     $realtime, why, want.status, want.reinit_request, want.stream_on,
                     " got status %0d reinit %0b stream %0b",
                     got.status, got.reinit_request, got.stream_on);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cfc_out_t want;

        if (!rst_n)
        begin
            verdict_q.delete();
            clear_packet();
            stream_en      = 1'b1;
            mismatch_count = 0;
            verdicts_owed  = 0;
        end
        else
        begin
            // The verdict for a closing byte is registered, so it cannot be taken
            // with that byte, and the order of these two steps does not matter.
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    flag_mismatch("with none expected", 'x, out_data);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (out_data.status !== want.status ||
                        out_data.reinit_request !== want.reinit_request ||
                        out_data.stream_on !== want.stream_on)
                    begin
                        flag_mismatch("differs", want, out_data);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                absorb_byte(in_data.rx_byte, in_data.last_byte);
            end
            verdicts_owed = verdict_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives command packets into the command frame checker: a directed set of
// good and damaged packets, then random packets and byte noise under three
// idling patterns, a long receiver hold-off and sender pauses. The checker
// module predicts and compares the verdicts; this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import cfc_pkg::*;

    localparam int unsigned RANDOM_BEATS = 720;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef enum int unsigned {
        MG_NONE,
        MG_HEADER,
        MG_CHECKSUM,
        MG_FOOTER,
        MG_TRAILER,
        MG_TRUNCATE,
        MG_EXTEND
    } damage_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    cfc_in_t     in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    cfc_out_t    out_data;

    int unsigned send_idle   = 14;
    int unsigned recv_idle   = 79;
    int unsigned hold_left   = 0;
    int unsigned beats_sent  = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count;
    int unsigned verdicts_owed;

    logic [7:0]  packet [$];
    int unsigned body_len;

    command_frame_checker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    cfc_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .mismatch_count (mismatch_count),
        .verdicts_owed  (verdicts_owed)
    );

    always #5 clk = ~clk;

    // Receiver: random back-pressure, or a solid hold-off while one is pending.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_data.rx_byte   <= b;
        in_data.last_byte <= last;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < packet.size(); i++)
        begin
            send_beat(packet[i], i == packet.size() - 1);
        end
    endtask

    task automatic build_packet(input logic [7:0] kind, input int unsigned len,
                                input logic [7:0] first, input logic newline);
        logic [7:0] sum;
        logic [7:0] b;

        packet.delete();
        for (int k = 0; k < 4; k++) packet.push_back(HEAD_MARK[k]);
        packet.push_back(kind);
        packet.push_back(len[7:0]);
        sum = kind ^ len[7:0];
        for (int i = 0; i < len; i++)
        begin
            b = (i == 0) ? first : 8'($urandom_range(255));
            packet.push_back(b);
            sum = sum ^ b;
        end
        packet.push_back(sum);
        for (int k = 0; k < 4; k++) packet.push_back(TAIL_MARK[k]);
        if (newline) packet.push_back(NEWLINE_BYTE);
        body_len = len;
    endtask

    task automatic damage(input damage_t mode);
        logic [7:0] flip;
        logic [7:0] stray;

        flip  = 8'($urandom_range(1, 255));
        stray = 8'($urandom_range(255));
        if (stray == NEWLINE_BYTE) stray = ~stray;
        case (mode)
            MG_HEADER:   packet[$urandom_range(3)] ^= flip;
            MG_CHECKSUM: packet[6 + body_len] ^= flip;
            MG_FOOTER:   packet[7 + body_len + $urandom_range(3)] ^= flip;
            MG_TRAILER:
                if (packet.size() == body_len + 12) packet[body_len + 11] = stray;
                else packet.push_back(stray);
            MG_TRUNCATE:
                repeat ($urandom_range(1, packet.size() - 1)) void'(packet.pop_back());
            MG_EXTEND:
                repeat ($urandom_range(1, 3)) packet.push_back(8'($urandom_range(255)));
            default: ;
        endcase
    endtask

    task automatic random_packet();
        logic [7:0]  kind;
        logic [7:0]  first;
        int unsigned len;
        int unsigned pick;

        pick = $urandom_range(99);
        len  = (pick < 80) ? $urandom_range(6) :
               (pick < 96) ? $urandom_range(7, 40) : $urandom_range(41, 255);
        pick = $urandom_range(9);
        kind = (pick < 4) ? KIND_REINIT :
               (pick < 8) ? KIND_STREAM : 8'($urandom_range(255));
        pick = $urandom_range(9);
        first = (pick < 4) ? ARG_ON : (pick < 8) ? ARG_OFF : 8'($urandom_range(255));
        build_packet(kind, len, first, 1'($urandom_range(1)));
        if ($urandom_range(99) < 35)
            damage(damage_t'($urandom_range(MG_HEADER, MG_EXTEND)));
        send_packet();
    endtask

    task automatic random_traffic(input int unsigned beats);
        int unsigned goal;

        goal = beats_sent + beats;
        while (beats_sent < goal)
        begin
            if ($urandom_range(19) == 0)
            begin
                // Loose bytes, closed off so that the next packet starts clean.
                repeat ($urandom_range(1, 15))
                begin
                    send_beat(8'($urandom_range(255)), $urandom_range(7) == 0);
                end
                send_beat(8'($urandom_range(255)), 1'b1);
            end
            else
            begin
                random_packet();
            end
        end
    endtask

    // The clock is waited on before the owed count is read, so that the scoreboard has taken the last accepted beat.
    task automatic quiet_sender();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (verdicts_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets.
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b1);
        build_packet(KIND_REINIT, 1, ARG_ON, 1'b0);
        send_packet();
        build_packet(KIND_STREAM, 2, ARG_OFF, 1'b1);
        send_packet();
        build_packet(KIND_STREAM, 1, 8'h03, 1'b0);
        send_packet();
        build_packet(KIND_REINIT, 0, ARG_ON, 1'b0);
        send_packet();
        build_packet(KIND_REINIT, 1, ARG_OFF, 1'b0);
        send_packet();
        build_packet(KIND_STREAM, 1, ARG_ON, 1'b1);
        send_packet();
        build_packet(8'h00, 3, ARG_ON, 1'b0);
        send_packet();
        // Ten bytes is the longest packet that is still short.
        build_packet(KIND_STREAM, 0, ARG_ON, 1'b0);
        void'(packet.pop_back());
        send_packet();
        for (int m = MG_HEADER; m <= MG_EXTEND; m++)
        begin
            build_packet(KIND_STREAM, 1, ARG_OFF, 1'(m % 2));
            damage(damage_t'(m));
            send_packet();
        end
        build_packet(KIND_STREAM, 255, ARG_OFF, 1'b1);
        send_packet();
        // Runs past the saturation point of the byte position.
        build_packet(KIND_STREAM, 255, ARG_ON, 1'b0);
        repeat (260) packet.push_back(8'($urandom_range(255)));
        send_packet();

        random_traffic(RANDOM_BEATS / 3);
        quiet_sender();

        send_idle = 79;
        recv_idle = 14;
        hold_left = HOLD_CYCLES;
        repeat (6) send_beat(8'($urandom_range(255)), 1'b1);
        random_traffic(RANDOM_BEATS / 3);
        quiet_sender();

        send_idle = 0;
        recv_idle = 0;
        random_traffic(RANDOM_BEATS / 3);

        quiet_sender();
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/cfc_pkg.sv
design/command_frame_checker.sv
test/cfc_checker.sv
test/tb.sv
